// ----- hdl/sorted_table_with_prime_subset_assert.svh -----
`ifndef SORTED_TABLE_WITH_PRIME_SUBSET_ASSERT_SVH
`define SORTED_TABLE_WITH_PRIME_SUBSET_ASSERT_SVH

// same-cycle implication, sampled on the rising edge, off during reset
`define STP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/stp_pkg.sv -----
package stp_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int VAL_W       = 32;
	localparam int OUT_CNT_W   = 7;
	localparam int DIV_W       = 17;
	localparam int DIV_BITS    = 2;
	localparam int DIV_STEPS   = VAL_W / DIV_BITS;
	localparam int DCNT_W      = $clog2(DIV_STEPS);

	typedef enum logic {
		ACT_ADD    = 1'b0,
		ACT_REMOVE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_MISSING = 2'd1,
		STAT_FULL    = 2'd2
	} status_t;

	typedef struct packed {
		logic load;
		logic mark_prime;
		logic mark_comp;
		logic div_init;
		logic div_step;
		logic next_div;
		logic scan_init;
		logic scan_sel;
		logic scan_rd;
		logic scan_chk;
		logic set_full;
		logic set_missing;
		logic out_load;
	} stp_cmd_t;

	typedef struct packed {
		logic below_two;
		logic sq_over;
		logic div_last;
		logic rem_zero;
		logic scan_end;
		logic is_add;
		logic full;
		logic prime;
		logic found;
		logic sel;
		logic out_free;
	} stp_sts_t;

endpackage

// ----- hdl/stp_in_if.sv -----
interface stp_in_if;
	import stp_pkg::*;

	logic               valid;
	logic               ready;
	logic               action;
	logic signed [31:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink (input valid, input action, input value, output ready);

endinterface

// ----- hdl/stp_out_if.sv -----
interface stp_out_if;
	import stp_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [6:0] element_count;
	logic [6:0] prime_count;
	logic       value_is_prime;

	modport source (output valid, output status, output element_count, output prime_count,
		output value_is_prime, input ready);
	modport sink (input valid, input status, input element_count, input prime_count,
		input value_is_prime, output ready);

endinterface

// ----- hdl/stp_ram.sv -----
module stp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/stp_ctrl.sv -----
module stp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  stp_pkg::stp_sts_t sts,
	output stp_pkg::stp_cmd_t cmd
);
	import stp_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_TEST     = 8'b0000_0010,
		ST_DIV      = 8'b0000_0100,
		ST_CHK      = 8'b0000_1000,
		ST_TBL      = 8'b0001_0000,
		ST_SCAN_RD  = 8'b0010_0000,
		ST_SCAN_CHK = 8'b0100_0000,
		ST_DONE     = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_TEST;
				end
			end
			ST_TEST: begin
				if (sts.below_two) begin
					cmd.mark_comp = 1'b1;
					state_d       = ST_TBL;
				end else if (sts.sq_over) begin
					cmd.mark_prime = 1'b1;
					state_d        = ST_TBL;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				if (sts.rem_zero) begin
					cmd.mark_comp = 1'b1;
					state_d       = ST_TBL;
				end else begin
					cmd.next_div = 1'b1;
					state_d      = ST_TEST;
				end
			end
			ST_TBL: begin
				if (sts.is_add && sts.full) begin
					cmd.set_full = 1'b1;
					state_d      = ST_DONE;
				end else begin
					cmd.scan_init = 1'b1;
					cmd.scan_sel  = 1'b0;
					state_d       = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_end) begin
					if (!sts.sel && sts.prime && (sts.is_add || sts.found)) begin
						cmd.scan_init = 1'b1;
						cmd.scan_sel  = 1'b1;
						state_d       = ST_SCAN_RD;
					end else begin
						cmd.set_missing = !sts.sel && !sts.is_add && !sts.found;
						state_d         = ST_DONE;
					end
				end else begin
					state_d = ST_SCAN_CHK;
				end
			end
			ST_SCAN_CHK: begin
				cmd.scan_chk = 1'b1;
				state_d      = ST_SCAN_RD;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hdl/stp_dp.sv -----
module stp_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  stp_pkg::stp_cmd_t cmd,
	output stp_pkg::stp_sts_t sts,
	input  logic              in_action,
	input  logic signed [31:0] in_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        out_status,
	output logic [6:0]        out_element_count,
	output logic [6:0]        out_prime_count,
	output logic              out_value_is_prime
);
	import stp_pkg::*;

	action_t                   act_q;
	logic signed [VAL_W-1:0]   val_q;
	logic [DIV_W-1:0]          d_q;
	logic [DIV_W-1:0]          rem_q;
	logic [VAL_W-1:0]          sh_q;
	logic [DCNT_W-1:0]         dcnt_q;
	logic                      prime_q;
	logic                      sel_q;
	logic [CNT_W-1:0]          k_q;
	logic                      found_q;
	logic                      placed_q;
	status_t                   stat_q;
	logic [CNT_W-1:0]          vcnt_q;
	logic [CNT_W-1:0]          pcnt_q;
	logic                      out_valid_q;

	logic                      is_add;
	logic [CNT_W-1:0]          cur_cnt;
	logic [CNT_W-1:0]          k_dec;
	logic                      scan_end;
	logic [2*DIV_W-1:0]        sq;
	logic [DIV_W-1:0]          rem_next;
	logic                      we;
	logic [IDX_W-1:0]          waddr;
	logic [VAL_W-1:0]          wdata;
	logic [IDX_W-1:0]          raddr;
	logic [VAL_W-1:0]          rdata_v;
	logic [VAL_W-1:0]          rdata_p;
	logic signed [VAL_W-1:0]   rdata;

	function automatic logic [DIV_W-1:0] rem_step(input logic [DIV_W-1:0] r,
		input logic b, input logic [DIV_W-1:0] d);
		logic [DIV_W:0] t;
		t = {r, b};
		if (t >= {1'b0, d}) begin
			t = t - {1'b0, d};
		end
		return t[DIV_W-1:0];
	endfunction

	assign is_add   = (act_q == ACT_ADD);
	assign cur_cnt  = sel_q ? pcnt_q : vcnt_q;
	assign k_dec    = k_q - CNT_W'(1);
	assign scan_end = is_add ? ((k_q == '0) || placed_q) : (k_q == cur_cnt);
	assign sq       = d_q * d_q;
	assign rem_next = rem_step(rem_step(rem_q, sh_q[VAL_W-1], d_q), sh_q[VAL_W-2], d_q);
	assign rdata    = $signed(sel_q ? rdata_p : rdata_v);
	assign raddr    = is_add ? k_dec[IDX_W-1:0] : k_q[IDX_W-1:0];

	always_comb begin
		we    = 1'b0;
		waddr = k_q[IDX_W-1:0];
		wdata = val_q;
		if (cmd.scan_rd && scan_end && is_add) begin
			we = 1'b1;
		end else if (cmd.scan_chk) begin
			wdata = rdata;
			if (is_add) begin
				we = (rdata >= val_q);
			end else begin
				we    = found_q;
				waddr = k_dec[IDX_W-1:0];
			end
		end
	end

	stp_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_values (
		.clk   (clk),
		.we    (we && !sel_q),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata_v)
	);

	stp_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_primes (
		.clk   (clk),
		.we    (we && sel_q),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata_p)
	);

	// trial division and scan registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= action_t'(in_action);
			val_q  <= in_value;
			d_q    <= DIV_W'(2);
			stat_q <= STAT_OK;
		end
		if (cmd.mark_prime) begin
			prime_q <= 1'b1;
		end
		if (cmd.mark_comp) begin
			prime_q <= 1'b0;
		end
		if (cmd.div_init) begin
			rem_q  <= '0;
			sh_q   <= val_q;
			dcnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= rem_next;
			sh_q   <= sh_q << DIV_BITS;
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
		if (cmd.next_div) begin
			d_q <= (d_q == DIV_W'(2)) ? DIV_W'(3) : d_q + DIV_W'(2);
		end
		if (cmd.scan_chk) begin
			if (is_add) begin
				if (rdata >= val_q) begin
					k_q <= k_dec;
				end else begin
					placed_q <= 1'b1;
				end
			end else begin
				if (!found_q && (rdata == val_q)) begin
					found_q <= 1'b1;
				end
				k_q <= k_q + CNT_W'(1);
			end
		end
		if (cmd.scan_init) begin
			sel_q    <= cmd.scan_sel;
			found_q  <= 1'b0;
			placed_q <= 1'b0;
			if (is_add) begin
				k_q <= cmd.scan_sel ? pcnt_q : vcnt_q;
			end else begin
				k_q <= '0;
			end
		end
		if (cmd.set_full) begin
			stat_q <= STAT_FULL;
		end
		if (cmd.set_missing) begin
			stat_q <= STAT_MISSING;
		end
	end

	// counts and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q      <= '0;
			pcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.scan_rd && scan_end && (is_add || found_q)) begin
				if (sel_q) begin
					pcnt_q <= is_add ? pcnt_q + CNT_W'(1) : pcnt_q - CNT_W'(1);
				end else begin
					vcnt_q <= is_add ? vcnt_q + CNT_W'(1) : vcnt_q - CNT_W'(1);
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status         <= stat_q;
			out_element_count  <= vcnt_q[OUT_CNT_W-1:0];
			out_prime_count    <= pcnt_q[OUT_CNT_W-1:0];
			out_value_is_prime <= prime_q;
		end
	end

	assign out_valid = out_valid_q;

	assign sts.below_two = (val_q < $signed(VAL_W'(2)));
	assign sts.sq_over   = (sq > {{(2*DIV_W-VAL_W){1'b0}}, val_q});
	assign sts.div_last  = (dcnt_q == DCNT_W'(DIV_STEPS - 1));
	assign sts.rem_zero  = (rem_q == '0);
	assign sts.scan_end  = scan_end;
	assign sts.is_add    = is_add;
	assign sts.full      = (vcnt_q == CNT_W'(TABLE_DEPTH));
	assign sts.prime     = prime_q;
	assign sts.found     = found_q;
	assign sts.sel       = sel_q;
	assign sts.out_free  = !out_valid_q || out_ready;

endmodule

// ----- hdl/sorted_table_with_prime_subset.sv -----
// Sorted table of up to 64 signed 32-bit values plus an ordered table of the prime ones.
// item channel: action (0 add, 1 remove) and value; one transfer per item.
// result channel: status, element_count, prime_count, value_is_prime; one per item.
// Items are handled one at a time; item ready is high only while the block is idle.
// Primality: trial division by 2 and then odd divisors d while d*d <= value, each
// divisor taking 16 steps in the shared radix-4 remainder unit.
// Worst case (large prime) about 23200 divisors.
// Table update: scan with shift in one RAM, a read state and a check state per entry
// moved or compared, done for the value table and then for the prime table when the
// value is prime (and, for a remove, was found).
// A finished result sits in an output register; the next item is accepted while
// it waits. If the receiver stalls with a result still held, the following item
// waits in its last state until the register frees.
// Reset clears both counts and the output valid flag; RAM contents are left as is.
module sorted_table_with_prime_subset (
	input logic      clk,
	input logic      arst_n,
	stp_in_if.sink   item,
	stp_out_if.source result
);
	import stp_pkg::*;

	stp_cmd_t cmd;
	stp_sts_t sts;

	stp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	stp_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.in_action          (item.action),
		.in_value           (item.value),
		.out_valid          (result.valid),
		.out_ready          (result.ready),
		.out_status         (result.status),
		.out_element_count  (result.element_count),
		.out_prime_count    (result.prime_count),
		.out_value_is_prime (result.value_is_prime)
	);

endmodule

// ----- hdl/stp_checker.sv -----
`include "sorted_table_with_prime_subset_assert.svh"

module stp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic [6:0] element_count,
	input logic [6:0] prime_count,
	input logic       value_is_prime
);
	import stp_pkg::*;

	`STP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(status) && $stable(element_count) && $stable(prime_count)
		&& $stable(value_is_prime),
		"result changed while stalled")

	`STP_ASSERT_NOW(a_subset, out_valid, prime_count <= element_count,
		"more primes than values")

	`STP_ASSERT_NOW(a_full_count, out_valid && (status == STAT_FULL),
		element_count == OUT_CNT_W'(TABLE_DEPTH), "full reported below capacity")

	`STP_ASSERT_NOW(a_status_code, out_valid,
		(status == STAT_OK) || (status == STAT_MISSING) || (status == STAT_FULL),
		"unknown status code")

endmodule

bind sorted_table_with_prime_subset stp_checker u_stp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.status         (result.status),
	.element_count  (result.element_count),
	.prime_count    (result.prime_count),
	.value_is_prime (result.value_is_prime)
);

// ----- sim/sorted_table_with_prime_subset_tb.sv -----
module sorted_table_with_prime_subset_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import stp_pkg::*;

	typedef struct {
		status_t    status;
		logic [6:0] element_count;
		logic [6:0] prime_count;
		logic       value_is_prime;
	} table_result_t;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   tx_idle;
	int   rx_idle;
	int   hold_cycles;

	stp_in_if  in_ch();
	stp_out_if out_ch();

	sorted_table_with_prime_subset uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_ch.sink),
		.result (out_ch.source)
	);

	task automatic report(string what, int got, int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	class table_mirror;
		int            values[$];
		int            primes[$];
		table_result_t pending_results[$];

		function automatic bit is_prime(int v);
			longint n;
			longint d;
			if (v < 2)
				return 0;
			n = v;
			for (d = 2; d * d <= n; d++)
				if (n % d == 0)
					return 0;
			return 1;
		endfunction

		function automatic void insert_sorted(ref int tab[$], input int v);
			int pos;
			pos = 0;
			while (pos < tab.size() && tab[pos] < v)
				pos++;
			tab.insert(pos, v);
		endfunction

		function automatic bit remove_first(ref int tab[$], input int v);
			foreach (tab[k])
				if (tab[k] == v) begin
					tab.delete(k);
					return 1;
				end
			return 0;
		endfunction

		function automatic void note_item(action_t act, int v);
			table_result_t r;
			bit p;
			p = is_prime(v);
			r.status = STAT_OK;
			if (act == ACT_ADD) begin
				if (values.size() >= TABLE_DEPTH)
					r.status = STAT_FULL;
				else begin
					insert_sorted(values, v);
					if (p)
						insert_sorted(primes, v);
				end
			end else begin
				if (remove_first(values, v)) begin
					if (p)
						void'(remove_first(primes, v));
				end else
					r.status = STAT_MISSING;
			end
			r.element_count = 7'(values.size());
			r.prime_count = 7'(primes.size());
			r.value_is_prime = p;
			pending_results.push_back(r);
		endfunction

		task automatic check_result(logic [1:0] st, logic [6:0] ec, logic [6:0] pc, logic ip);
			table_result_t r;
			if (pending_results.size() == 0) begin
				report("unexpected result, status", st, -1);
				return;
			end
			r = pending_results.pop_front();
			if (st !== r.status)
				report("status", st, r.status);
			if (ec !== r.element_count)
				report("element_count", ec, r.element_count);
			if (pc !== r.prime_count)
				report("prime_count", pc, r.prime_count);
			if (ip !== r.value_is_prime)
				report("value_is_prime", ip, r.value_is_prime);
		endtask
	endclass

	table_mirror mirror = new();

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#40ms;
		$display("sorted_table_with_prime_subset_tb: errors");
		$finish;
	end

	// receiver: random stalls plus an occasional long hold-off
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ch.ready <= 1'b0;
				hold_cycles--;
			end else
				out_ch.ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	always @(posedge clk)
		if (arst_n && out_ch.valid && out_ch.ready)
			mirror.check_result(out_ch.status, out_ch.element_count, out_ch.prime_count,
				out_ch.value_is_prime);

	task automatic send(action_t act, int v);
		while ($urandom_range(99) < tx_idle) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.action <= act;
		in_ch.value <= v;
		do
			@(posedge clk);
		while (!in_ch.ready);
		mirror.note_item(act, v);
		@(negedge clk);
	endtask

	function automatic int pick_value();
		int sel;
		sel = $urandom_range(3);
		if (sel < 2)
			return $urandom_range(220) - 20;
		if (sel == 2)
			return int'($urandom() & 32'h7fff_fffe);
		return int'($urandom() | 32'h8000_0000);
	endfunction

	task automatic send_random();
		int held;
		held = mirror.values.size();
		if ($urandom_range(99) < 55)
			send(ACT_ADD, pick_value());
		else if (held > 0 && $urandom_range(99) < 70)
			send(ACT_REMOVE, mirror.values[$urandom_range(held - 1)]);
		else
			send(ACT_REMOVE, pick_value());
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (mirror.pending_results.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		mismatches = 0;
		hold_cycles = 0;
		tx_idle = 29;
		rx_idle = 53;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.action = ACT_ADD;
		in_ch.value = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send(ACT_ADD, 0);
		send(ACT_ADD, -1);
		send(ACT_ADD, 1);
		send(ACT_ADD, 2);
		send(ACT_ADD, 3);
		send(ACT_ADD, 2);
		send(ACT_ADD, 32'sh7fff_ffff);
		send(ACT_ADD, 32'sh8000_0000);
		send(ACT_ADD, 4);
		send(ACT_ADD, 9);
		send(ACT_ADD, 25);
		send(ACT_ADD, 32'sh7fff_fffe);
		send(ACT_REMOVE, 2);
		send(ACT_REMOVE, 7);
		send(ACT_REMOVE, 32'sh7fff_ffff);
		send(ACT_REMOVE, 32'sh8000_0000);
		send(ACT_ADD, 97);
		send(ACT_REMOVE, 100);
		send(ACT_REMOVE, 0);
		send(ACT_REMOVE, 97);
		drain();

		// fill until the table is full, with a long receiver hold-off on the way
		while (mirror.values.size() < TABLE_DEPTH) begin
			if (mirror.values.size() == 30)
				hold_cycles = 300;
			send(ACT_ADD, pick_value());
		end
		repeat (3) send(ACT_ADD, pick_value());
		send(ACT_REMOVE, mirror.values[TABLE_DEPTH - 1]);
		send(ACT_ADD, pick_value());
		send(ACT_ADD, 5);
		drain();

		tx_idle = 53;
		rx_idle = 29;
		repeat (12) send_random();
		drain();

		tx_idle = 0;
		rx_idle = 0;
		repeat (12) send_random();
		drain();

		repeat (50) @(negedge clk);
		if (mismatches == 0 && mirror.pending_results.size() == 0)
			$display("sorted_table_with_prime_subset_tb: clean");
		else
			$display("sorted_table_with_prime_subset_tb: errors");
		$finish;
	end

endmodule
